FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the top-level RTL file
// Concurrent checks sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Types and constants of the escape-time pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_X_ORIGIN  = 3'd0;
  localparam logic [2:0] REG_X_INC     = 3'd1;
  localparam logic [2:0] REG_Y_ORIGIN  = 3'd2;
  localparam logic [2:0] REG_Y_INC     = 3'd3;
  localparam logic [2:0] REG_LIMIT     = 3'd4;
  localparam logic [2:0] REG_HIGH_PREC = 3'd5;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned COUNT_W = LIMIT_W + 1;
  localparam int unsigned PAL_W   = 4;

  localparam int unsigned HI_FRAC = 26;
  localparam int unsigned LO_FRAC = 10;
  localparam int unsigned LO_CUT  = 16;

  // Escape thresholds: four in s5.26 and in s5.10
  localparam logic signed [31:0] ESC_HI = 32'sd4 <<< HI_FRAC;
  localparam logic signed [31:0] ESC_LO = 32'sd4 <<< LO_FRAC;

  localparam logic [PAL_W-1:0] PAL_INSIDE = 4'd8;

  typedef struct packed {
    logic signed [31:0]  x_origin;
    logic [30:0]         x_increment;
    logic signed [31:0]  y_origin;
    logic [30:0]         y_increment;
    logic [LIMIT_W-1:0]  iteration_limit;
    logic                high_precision;
  } cfg_t;

  // Point handed from the front to the iteration engine
  typedef struct packed {
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } point_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mbe_front.sv
// ----------------------------------------------------------------------------
// mbe_front
// Accepts pixels and maps them to points c in the selected number format.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mbe_pkg::cfg_t                cfg_i,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire logic [mbe_pkg::COORD_W-1:0]  column_i,
  input  wire logic [mbe_pkg::COORD_W-1:0]  row_i,
  output logic                              q_push_o,
  output mbe_pkg::point_t                   q_data_o,
  input  wire logic                         q_full_i
);

  logic                        a_valid_q, a_valid_d;
  logic [mbe_pkg::COORD_W-1:0] col_q, row_q;
  logic                        b_valid_q, b_valid_d;
  logic [31:0]                 px_q, py_q;
  logic                        a_adv, b_adv, accept;
  logic [40:0]                 px_full, py_full;
  logic [31:0]                 cr32, ci32;

  // Stage handshakes: each stage moves when the one after it has room
  assign b_adv  = b_valid_q && !q_full_i;
  assign a_adv  = a_valid_q && (!b_valid_q || b_adv);
  assign accept = push_i && (!a_valid_q || a_adv);
  assign full_o = a_valid_q && !a_adv;

  assign a_valid_d = accept ? 1'b1 : (a_adv ? 1'b0 : a_valid_q);
  assign b_valid_d = a_adv  ? 1'b1 : (b_adv ? 1'b0 : b_valid_q);

  // Index times step, wrapped to 32 bits
  assign px_full = 41'(col_q) * 41'(cfg_i.x_increment);
  assign py_full = 41'(row_q) * 41'(cfg_i.y_increment);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  // Capture pixel and products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= column_i;
      row_q <= row_i;
    end
    if (a_adv) begin
      px_q <= px_full[31:0];
      py_q <= py_full[31:0];
    end
  end

  // Add origin, then cut to s5.10 in low mode
  assign cr32 = cfg_i.x_origin + px_q;
  assign ci32 = cfg_i.y_origin + py_q;

  always_comb begin
    if (cfg_i.high_precision) begin
      q_data_o.cr = cr32;
      q_data_o.ci = ci32;
    end else begin
      q_data_o.cr = {{mbe_pkg::LO_CUT{cr32[31]}}, cr32[31:mbe_pkg::LO_CUT]};
      q_data_o.ci = {{mbe_pkg::LO_CUT{ci32[31]}}, ci32[31:mbe_pkg::LO_CUT]};
    end
  end

  assign q_push_o = b_adv;

endmodule

`default_nettype wire

FILE: hw/rtl/mbe_queue.sv
// ----------------------------------------------------------------------------
// mbe_queue
// Small register queue between the front and the iteration engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_queue #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mbe_iter.sv
// ----------------------------------------------------------------------------
// mbe_iter
// Escape-time iteration engine with a one-entry result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_iter #(
  parameter int unsigned ITER_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mbe_pkg::cfg_t             cfg_i,
  input  wire mbe_pkg::point_t           q_data_i,
  input  wire logic                      q_empty_i,
  output logic                           q_pop_o,
  output logic                           empty_o,
  input  wire logic                      pop_i,
  output logic [ITER_BITS-1:0]           iteration_count_o,
  output logic                           escaped_o,
  output logic [mbe_pkg::PAL_W-1:0]      palette_index_o
);

  localparam int unsigned SAT_W = (ITER_BITS > mbe_pkg::COUNT_W) ? ITER_BITS
                                                                 : mbe_pkg::COUNT_W;
  localparam logic [SAT_W-1:0] CNT_MAX = SAT_W'((64'd1 << ITER_BITS) - 64'd1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic signed [31:0]           cr_q, ci_q, x_q, y_q, x_d, y_d;
  logic signed [63:0]           xx_q, yy_q, xy_q;
  logic [mbe_pkg::COUNT_W-1:0]  count_q, count_d;
  logic                         esc_q, esc_d;
  logic                         res_valid_q, res_valid_d;
  logic [ITER_BITS-1:0]         res_count_q;
  logic                         res_esc_q;
  logic [mbe_pkg::PAL_W-1:0]    res_pal_q;
  logic signed [31:0]           x2, y2, xy, sum, thresh, x_new, y_new;
  logic                         over_limit, res_load, do_start, do_mul;
  logic [SAT_W-1:0]             cnt_ext, cnt_sat;

  assign over_limit = (count_q > {1'b0, cfg_i.iteration_limit});
  assign res_load   = (state_q == ST_DONE) && (!res_valid_q || pop_i);
  assign do_start   = (state_q == ST_IDLE) && !q_empty_i;
  assign do_mul     = (state_q == ST_MUL) && !over_limit;
  assign q_pop_o    = do_start;

  // Rescale products to the working format
  always_comb begin
    if (cfg_i.high_precision) begin
      x2     = xx_q[mbe_pkg::HI_FRAC+31:mbe_pkg::HI_FRAC];
      y2     = yy_q[mbe_pkg::HI_FRAC+31:mbe_pkg::HI_FRAC];
      xy     = xy_q[mbe_pkg::HI_FRAC+31:mbe_pkg::HI_FRAC];
      thresh = mbe_pkg::ESC_HI;
    end else begin
      x2     = {{16{xx_q[mbe_pkg::LO_FRAC+15]}}, xx_q[mbe_pkg::LO_FRAC+15:mbe_pkg::LO_FRAC]};
      y2     = {{16{yy_q[mbe_pkg::LO_FRAC+15]}}, yy_q[mbe_pkg::LO_FRAC+15:mbe_pkg::LO_FRAC]};
      xy     = {{16{xy_q[mbe_pkg::LO_FRAC+15]}}, xy_q[mbe_pkg::LO_FRAC+15:mbe_pkg::LO_FRAC]};
      thresh = mbe_pkg::ESC_LO;
    end
    sum   = x2 + y2;
    x_new = x2 - y2 + cr_q;
    y_new = (xy <<< 1) + ci_q;
  end

  // Sequence one pixel: check the limit and multiply, then add and test
  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    count_d = count_q;
    esc_d   = esc_q;
    case (state_q)
      ST_IDLE: begin
        if (do_start) begin
          x_d     = q_data_i.cr;
          y_d     = q_data_i.ci;
          count_d = mbe_pkg::COUNT_W'(1);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (over_limit) begin
          esc_d   = 1'b0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (sum > thresh) begin
          esc_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          if (cfg_i.high_precision) begin
            x_d = x_new;
            y_d = y_new;
          end else begin
            x_d = {{16{x_new[15]}}, x_new[15:0]};
            y_d = {{16{y_new[15]}}, y_new[15:0]};
          end
          count_d = count_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold result until popped
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end
  end

  // Saturate the reported count
  assign cnt_ext = SAT_W'(count_q);
  assign cnt_sat = (cnt_ext > CNT_MAX) ? CNT_MAX : cnt_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    count_q <= count_d;
    esc_q   <= esc_d;
    if (do_start) begin
      cr_q <= q_data_i.cr;
      ci_q <= q_data_i.ci;
    end
    if (do_mul) begin
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      xy_q <= x_q * y_q;
    end
    if (res_load) begin
      res_count_q <= cnt_sat[ITER_BITS-1:0];
      res_esc_q   <= esc_q;
      res_pal_q   <= esc_q ? {1'b0, count_q[2:0]} : mbe_pkg::PAL_INSIDE;
    end
  end

  assign empty_o           = !res_valid_q;
  assign iteration_count_o = res_count_q;
  assign escaped_o         = res_esc_q;
  assign palette_index_o   = res_pal_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Fixed-point escape-time pixel engine: pixel in, iteration count out.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// pixel     in         push / full             column_i, row_from_bottom_i
// result    out        empty / pop             iteration_count_o, escaped_o,
//                                              palette_index_o
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A pixel passes the front's pixel and product registers, then the queue.
// The engine then runs a multiply step and an add-and-test step for each
// iteration until the pixel escapes at iteration n or all n = limit
// iterations have run (one more multiply step then tests the limit), loads
// the result register and returns to idle before it takes the next pixel.
// Reset clears the handshake state and loads the register defaults. A stalled
// result holds the engine in its done state; a full queue stalls the front.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mandelbrot_escape_time #(
  parameter int unsigned ITER_BITS   = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [mbe_pkg::COORD_W-1:0]  column_i,
  input  wire logic [mbe_pkg::COORD_W-1:0]  row_from_bottom_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [ITER_BITS-1:0]              iteration_count_o,
  output logic                              escaped_o,
  output logic [mbe_pkg::PAL_W-1:0]         palette_index_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [2:0]                   cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i
);

  mbe_pkg::cfg_t   cfg_q;
  mbe_pkg::point_t q_wdata, q_rdata;
  logic            q_push, q_full, q_pop, q_empty, cfg_we, limit_we;
  logic [mbe_pkg::LIMIT_W-1:0] limit_wdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign limit_we    = cfg_we && (cfg_index_i == mbe_pkg::REG_LIMIT);
  assign limit_wdata = cfg_data_i[mbe_pkg::LIMIT_W-1:0];

  // Configuration registers; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin        <= 32'shF700_0000;
      cfg_q.x_increment     <= 31'h0010_0000;
      cfg_q.y_origin        <= 32'shFB33_3333;
      cfg_q.y_increment     <= 31'h0010_0000;
      cfg_q.iteration_limit <= 16'd15;
      cfg_q.high_precision  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        mbe_pkg::REG_X_ORIGIN:  cfg_q.x_origin        <= cfg_data_i;
        mbe_pkg::REG_X_INC:     cfg_q.x_increment     <= cfg_data_i[30:0];
        mbe_pkg::REG_Y_ORIGIN:  cfg_q.y_origin        <= cfg_data_i;
        mbe_pkg::REG_Y_INC:     cfg_q.y_increment     <= cfg_data_i[30:0];
        mbe_pkg::REG_LIMIT:     cfg_q.iteration_limit <= limit_wdata;
        mbe_pkg::REG_HIGH_PREC: cfg_q.high_precision  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  mbe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push_i   (push),
    .full_o   (full),
    .column_i (column_i),
    .row_i    (row_from_bottom_i),
    .q_push_o (q_push),
    .q_data_o (q_wdata),
    .q_full_i (q_full)
  );

  mbe_queue #(
    .WIDTH ($bits(mbe_pkg::point_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  mbe_iter #(
    .ITER_BITS (ITER_BITS)
  ) u_iter (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_data_i          (q_rdata),
    .q_empty_i         (q_empty),
    .q_pop_o           (q_pop),
    .empty_o           (empty),
    .pop_i             (pop),
    .iteration_count_o (iteration_count_o),
    .escaped_o         (escaped_o),
    .palette_index_o   (palette_index_o)
  );

  // Checks
  `ASSERT_IMPL(a_front_no_overflow, q_push, !q_full)
  `ASSERT_IMPL(a_inside_palette, !empty && !escaped_o, palette_index_o == mbe_pkg::PAL_INSIDE)
  `ASSERT_IMPL(a_escape_palette, !empty && escaped_o, !palette_index_o[3] && |iteration_count_o)
  `ASSERT_NEXT(a_limit_write, limit_we, cfg_q.iteration_limit == $past(limit_wdata))

endmodule

`default_nettype wire
